// File: sv/cbq_pkg.sv
// Shared types, widths and helpers for the cascaded biquad filter.
`default_nettype none

package cbq_pkg;

    // Field and coefficient widths
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 18;
    localparam int STAGE_CNT_W = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = COEF_W;

    // Datapath widths: 18x16 product, five-term sum, sum plus rounding offset
    localparam int PROD_W = COEF_W + SAMPLE_W;
    localparam int SUM_W  = PROD_W + 3;
    localparam int RND_W  = SUM_W + 1;

    // Defaults for the top-level parameters
    localparam int MAX_STAGES_DEF     = 8;
    localparam int COEF_FRAC_BITS_DEF = 14;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_IN0    = 3'd0,
        CFG_COEF_IN1    = 3'd1,
        CFG_COEF_IN2    = 3'd2,
        CFG_COEF_FB1    = 3'd3,
        CFG_COEF_FB2    = 3'd4,
        CFG_STAGE_COUNT = 3'd5
    } cfg_index_t;

    // Reset values of the registers
    localparam logic signed [COEF_W-1:0]  COEF_IN0_RST    = 18'sd16384;
    localparam logic signed [COEF_W-1:0]  COEF_ZERO_RST   = 18'sd0;
    localparam logic [STAGE_CNT_W-1:0]    STAGE_COUNT_RST = 4'd1;

    // One coefficient set, shared by all sections
    typedef struct packed {
        logic signed [COEF_W-1:0] in0;
        logic signed [COEF_W-1:0] in1;
        logic signed [COEF_W-1:0] in2;
        logic signed [COEF_W-1:0] fb1;
        logic signed [COEF_W-1:0] fb2;
    } coef_set_t;

    // Word handed from one section cell to the next
    typedef struct packed {
        logic                       valid;
        logic [STAGE_CNT_W-1:0]     remain;  // sections still to run
        logic signed [SAMPLE_W-1:0] data;
    } cbq_token_t;

    // Full-precision coefficient times sample
    function automatic logic signed [PROD_W-1:0] coef_mul(
        input logic signed [COEF_W-1:0]   c,
        input logic signed [SAMPLE_W-1:0] s
    );
        return PROD_W'(c) * PROD_W'(s);
    endfunction

endpackage

`default_nettype wire

// File: sv/cascaded_biquad_iir_filter_unit.sv
// Cascaded direct-form-1 biquad filter: register bank, chain of section cells, output word.
//
// Usage:
//   Input words arrive on s_valid/s_ready/s_sample_in, results leave on
//   m_valid/m_ready/m_sample_out, one result word per input word, in order.
//   Coefficients and the section count are written through cfg_wr_en,
//   cfg_index and cfg_wr_data while no word is in flight; indexes past the
//   register map are ignored. A section count above MAX_STAGES acts as
//   MAX_STAGES; a count of zero passes the sample through unchanged.
//   Each active cell takes the word through its multiply, sum and
//   round/saturate registers, each idle cell passes it along through one
//   register, and the output register holds the result. One word is in the
//   chain at a time, so a new word is taken once the previous result is in
//   the output register and is being taken (m_ready high) or has left.
//   While the receiver stalls, the result stays in the output register and
//   s_ready stays low. Reset clears all section histories, loads the
//   register reset values (unity gain on the current input, one section)
//   and empties the chain and the output register.
`default_nettype none

module cascaded_biquad_iir_filter_unit import cbq_pkg::*; #(
    parameter int MAX_STAGES     = MAX_STAGES_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // configuration
    input  wire logic                       cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_wr_data,
    // input samples
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic signed [SAMPLE_W-1:0] s_sample_in,
    // filtered samples
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [SAMPLE_W-1:0]      m_sample_out
);

    localparam logic [STAGE_CNT_W-1:0] STAGE_LIMIT =
        (MAX_STAGES >= 15) ? 4'd15 : STAGE_CNT_W'(MAX_STAGES);

    coef_set_t                  coef_reg;
    logic [STAGE_CNT_W-1:0]     stage_count_reg;
    logic                       busy_reg;
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_sample_out_reg;

    logic                       in_fire;
    logic [STAGE_CNT_W-1:0]     stages_used;
    cbq_token_t                 tok [MAX_STAGES+1];
    logic [MAX_STAGES:0]        tok_valid_vec;

    // Clamp the section count to the cells present
    assign stages_used = (stage_count_reg > STAGE_LIMIT) ? STAGE_LIMIT : stage_count_reg;

    assign s_ready = !busy_reg && (!m_valid_reg || m_ready);
    assign in_fire = s_valid && s_ready;

    // Head of the chain
    assign tok[0].valid  = in_fire;
    assign tok[0].remain = stages_used;
    assign tok[0].data   = s_sample_in;

    // Chain of section cells
    for (genvar i = 0; i < MAX_STAGES; i++) begin : g_cell
        cbq_cell #(
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .coef    (coef_reg),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    for (genvar i = 0; i <= MAX_STAGES; i++) begin : g_valid
        assign tok_valid_vec[i] = tok[i].valid;
    end

    // Register bank and flow control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.in0    <= COEF_IN0_RST;
            coef_reg.in1    <= COEF_ZERO_RST;
            coef_reg.in2    <= COEF_ZERO_RST;
            coef_reg.fb1    <= COEF_ZERO_RST;
            coef_reg.fb2    <= COEF_ZERO_RST;
            stage_count_reg <= STAGE_COUNT_RST;
            busy_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_index))
                    CFG_COEF_IN0:    coef_reg.in0    <= cfg_wr_data;
                    CFG_COEF_IN1:    coef_reg.in1    <= cfg_wr_data;
                    CFG_COEF_IN2:    coef_reg.in2    <= cfg_wr_data;
                    CFG_COEF_FB1:    coef_reg.fb1    <= cfg_wr_data;
                    CFG_COEF_FB2:    coef_reg.fb2    <= cfg_wr_data;
                    CFG_STAGE_COUNT: stage_count_reg <= cfg_wr_data[STAGE_CNT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (in_fire) begin
                busy_reg <= 1'b1;
            end else if (tok[MAX_STAGES].valid) begin
                busy_reg <= 1'b0;
            end
            if (tok[MAX_STAGES].valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Output word
    always_ff @(posedge aclk) begin
        if (tok[MAX_STAGES].valid) begin
            m_sample_out_reg <= tok[MAX_STAGES].data;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_out_reg;

    // At most one word travels the chain
    assert property (@(posedge aclk) disable iff (!aresetn) $onehot0(tok_valid_vec))
        else $error("more than one word in the section chain");

    // A word leaving the chain never lands on an unread result
    assert property (@(posedge aclk) disable iff (!aresetn)
        tok[MAX_STAGES].valid |-> (busy_reg && !m_valid_reg))
        else $error("chain result would overwrite a pending output");

    // An accepted word keeps the block busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (busy_reg && !s_ready))
        else $error("input taken while a word is in flight");

endmodule

`default_nettype wire

// File: sv/cbq_cell.sv
// One biquad section cell: history, product, sum and round/saturate stages.
`default_nettype none

module cbq_cell import cbq_pkg::*; #(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire coef_set_t  coef,
    input  wire cbq_token_t tok_in,
    output cbq_token_t      tok_out
);

    localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [RND_W-1:0] SAT_MAX  = RND_W'(32767);
    localparam logic signed [RND_W-1:0] SAT_MIN  = -RND_W'(32768);

    // Section history
    logic signed [SAMPLE_W-1:0] x1_reg, x2_reg, y1_reg, y2_reg;

    // Pipeline control
    logic mul_valid_reg, sum_valid_reg, out_valid_reg;

    // Pipeline payload
    logic signed [PROD_W-1:0]   p_in0_reg, p_in1_reg, p_in2_reg, p_fb1_reg, p_fb2_reg;
    logic signed [SAMPLE_W-1:0] x_hold_reg;
    logic [STAGE_CNT_W-1:0]     remain_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [STAGE_CNT_W-1:0]     out_remain_reg;
    logic signed [SAMPLE_W-1:0] out_data_reg;

    logic                       run_in;
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [RND_W-1:0]    rnd_sum;
    logic signed [RND_W-1:0]    rnd_shift;
    logic signed [SAMPLE_W-1:0] y_next;

    assign run_in = tok_in.valid && (tok_in.remain != '0);

    // Five-term accumulate, feedback terms subtracted
    assign sum_next = SUM_W'(p_in0_reg) + SUM_W'(p_in1_reg) + SUM_W'(p_in2_reg)
                    - SUM_W'(p_fb1_reg) - SUM_W'(p_fb2_reg);

    // Round half up, then clamp to 16 bits
    always_comb begin
        rnd_sum   = RND_W'(sum_reg) + RND_HALF;
        rnd_shift = rnd_sum >>> COEF_FRAC_BITS;
        if (rnd_shift > SAT_MAX) begin
            y_next = SAMPLE_W'(SAT_MAX);
        end else if (rnd_shift < SAT_MIN) begin
            y_next = SAMPLE_W'(SAT_MIN);
        end else begin
            y_next = rnd_shift[SAMPLE_W-1:0];
        end
    end

    // Control and history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            x1_reg        <= '0;
            x2_reg        <= '0;
            y1_reg        <= '0;
            y2_reg        <= '0;
        end else begin
            mul_valid_reg <= run_in;
            sum_valid_reg <= mul_valid_reg;
            // idle sections pass the word straight on to the output register
            out_valid_reg <= sum_valid_reg || (tok_in.valid && !run_in);
            if (sum_valid_reg) begin
                x2_reg <= x1_reg;
                x1_reg <= x_hold_reg;
                y2_reg <= y1_reg;
                y1_reg <= y_next;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (run_in) begin
            p_in0_reg  <= coef_mul(coef.in0, tok_in.data);
            p_in1_reg  <= coef_mul(coef.in1, x1_reg);
            p_in2_reg  <= coef_mul(coef.in2, x2_reg);
            p_fb1_reg  <= coef_mul(coef.fb1, y1_reg);
            p_fb2_reg  <= coef_mul(coef.fb2, y2_reg);
            x_hold_reg <= tok_in.data;
            remain_reg <= tok_in.remain - STAGE_CNT_W'(1);
        end
        if (mul_valid_reg) begin
            sum_reg <= sum_next;
        end
        if (sum_valid_reg) begin
            out_data_reg   <= y_next;
            out_remain_reg <= remain_reg;
        end else if (tok_in.valid) begin
            out_data_reg   <= tok_in.data;
            out_remain_reg <= tok_in.remain;
        end
    end

    assign tok_out.valid  = out_valid_reg;
    assign tok_out.remain = out_remain_reg;
    assign tok_out.data   = out_data_reg;

endmodule

`default_nettype wire
